// ===== src/frustum_box_cull_assert.svh =====
// assertion macros shared by the frustum cull rtl
`ifndef FRUSTUM_BOX_CULL_ASSERT_SVH
`define FRUSTUM_BOX_CULL_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define FBC_ASSERT_NOW(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("assertion failed");
// implication checked in the following cycle
`define FBC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("assertion failed");
`else
`define FBC_ASSERT_NOW(label, clk, rst_n, cond, expr)
`define FBC_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

// ===== src/fbc_pkg.sv =====
`default_nettype none

package fbc_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int DATA_W     = 32;
	localparam int COEF_W     = DATA_W + 1;
	localparam int PROD_W     = COEF_W + DATA_W;
	localparam int WTERM_W    = COEF_W + FRAC_BITS;
	// three products plus the shifted w term, two bits of growth
	localparam int SUM_W      = ((PROD_W > WTERM_W) ? PROD_W : WTERM_W) + 2;
	localparam int NUM_PLANES = 6;
	localparam int NUM_COEFS  = 4;

	localparam int PL_LEFT   = 0;
	localparam int PL_RIGHT  = 1;
	localparam int PL_TOP    = 2;
	localparam int PL_BOTTOM = 3;
	localparam int PL_NEAR   = 4;
	localparam int PL_FAR    = 5;

	localparam int CO_X = 0;
	localparam int CO_Y = 1;
	localparam int CO_Z = 2;
	localparam int CO_W = 3;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TEST = 1'b1;

	// operands of one plane for the multiply stage
	typedef struct packed {
		logic signed [COEF_W-1:0] cx;
		logic signed [COEF_W-1:0] cy;
		logic signed [COEF_W-1:0] cz;
		logic signed [COEF_W-1:0] cw;
		logic signed [DATA_W-1:0] vx;
		logic signed [DATA_W-1:0] vy;
		logic signed [DATA_W-1:0] vz;
	} plane_ops_t;

	// one matrix row written into the plane store
	typedef struct packed {
		logic                     wr_en;
		logic [1:0]               row;
		logic signed [DATA_W-1:0] c1;
		logic signed [DATA_W-1:0] c2;
		logic signed [DATA_W-1:0] c3;
		logic signed [DATA_W-1:0] c4;
	} row_wr_t;

endpackage

`default_nettype wire

// ===== src/fbc_plane_store.sv =====
`default_nettype none

module fbc_plane_store (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire fbc_pkg::row_wr_t                 wr,
	output logic signed [fbc_pkg::COEF_W-1:0]     coef [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_COEFS]
);
	import fbc_pkg::*;

	logic signed [COEF_W-1:0] coef_q [NUM_PLANES][NUM_COEFS];
	logic signed [COEF_W-1:0] e1, e2, e3, e4;

	assign e1 = COEF_W'(wr.c1);
	assign e2 = COEF_W'(wr.c2);
	assign e3 = COEF_W'(wr.c3);
	assign e4 = COEF_W'(wr.c4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				for (int k = 0; k < NUM_COEFS; k++) begin
					coef_q[p][k] <= '0;
				end
			end
		end else if (wr.wr_en) begin
			// one row gives the same coefficient of every plane
			coef_q[PL_LEFT][wr.row]   <= e4 + e1;
			coef_q[PL_RIGHT][wr.row]  <= e4 - e1;
			coef_q[PL_TOP][wr.row]    <= e4 - e2;
			coef_q[PL_BOTTOM][wr.row] <= e4 + e2;
			coef_q[PL_NEAR][wr.row]   <= e3;
			coef_q[PL_FAR][wr.row]    <= e4 - e3;
		end
	end

	assign coef = coef_q;

endmodule

`default_nettype wire

// ===== src/fbc_plane_eval.sv =====
`default_nettype none

module fbc_plane_eval (
	input  wire logic                clk,
	input  wire logic                s3_en,
	input  wire fbc_pkg::plane_ops_t ops,
	output logic                     outside
);
	import fbc_pkg::*;

	logic signed [PROD_W-1:0] prod_x_s3, prod_y_s3, prod_z_s3;
	logic signed [SUM_W-1:0]  wterm_s3;
	logic signed [SUM_W-1:0]  wterm;
	logic signed [SUM_W-1:0]  plane_dist;

	assign wterm = SUM_W'(ops.cw) <<< FRAC_BITS;

	always_ff @(posedge clk) begin
		if (s3_en) begin
			prod_x_s3 <= PROD_W'(ops.cx) * PROD_W'(ops.vx);
			prod_y_s3 <= PROD_W'(ops.cy) * PROD_W'(ops.vy);
			prod_z_s3 <= PROD_W'(ops.cz) * PROD_W'(ops.vz);
			wterm_s3  <= wterm;
		end
	end

	// exact distance of the positive vertex, only its sign matters
	assign plane_dist = SUM_W'(prod_x_s3) + SUM_W'(prod_y_s3) + SUM_W'(prod_z_s3) + wterm_s3;
	assign outside = plane_dist[SUM_W-1];

endmodule

`default_nettype wire

// ===== src/frustum_box_cull.sv =====
// frustum_box_cull: tests axis-aligned boxes against six view frustum planes.
// input words arrive on s_tvalid/s_tready; s_tuser bit 0 is the action.
// a load word (action 0) carries one view-projection matrix row selected
// by s_tuser[2:1]; it updates the plane coefficients and gives no result.
// a test word (action 1) carries two box corners and gives one result word
// on m_tvalid/m_tready whose bit 0 is 1 when the box may be visible.
// throughput is one word per cycle: the six planes each have their own three
// multipliers, and a new word is taken every cycle the pipeline can move.
// a test word goes from input acceptance to m_tvalid through the input register,
// operand register, product register, then the result register.
// a load takes effect for every test word accepted after it.
// when m_tready is low the stages fill up one by one; s_tready drops only
// once every stage holds a test word. empty stages keep taking words.
// reset clears all plane coefficients to zero, so every plane reads as
// (0,1,0,0) and a box is visible exactly when its larger y is >= 0.
`default_nettype none

module frustum_box_cull (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// m_col1, m_col2, m_col3, m_col4, box_min_x, box_min_y, box_min_z,
	// box_max_x, box_max_y, box_max_z
	input  wire logic [319:0] s_tdata,
	// action, row_sel
	input  wire logic [2:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// visible, zero fill
	output logic [7:0]        m_tdata
);
	import fbc_pkg::*;

	`include "frustum_box_cull_assert.svh"

	logic                     v1_q, v2_q, v3_q, out_v_q;
	logic                     act_s1;
	logic [1:0]               row_s1;
	logic signed [DATA_W-1:0] col_s1 [4];
	logic signed [DATA_W-1:0] ca_s1 [3];
	logic signed [DATA_W-1:0] cb_s1 [3];
	logic                     visible_q;

	logic                     out_free, s3_go, s2_go, s1_leave, in_acc;
	logic signed [DATA_W-1:0] lo [3];
	logic signed [DATA_W-1:0] hi [3];
	logic signed [COEF_W-1:0] coef [NUM_PLANES][NUM_COEFS];
	row_wr_t                  row_wr;
	plane_ops_t               ops [NUM_PLANES];
	plane_ops_t               ops_s2 [NUM_PLANES];
	logic [NUM_PLANES-1:0]    outside;

	assign out_free = !out_v_q || m_tready;
	assign s3_go    = !v3_q || out_free;
	assign s2_go    = !v2_q || s3_go;
	// a load word retires from the input register without going further
	assign s1_leave = v1_q && ((act_s1 == ACT_LOAD) || s2_go);
	assign s_tready = !v1_q || s1_leave;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s_tready) v1_q <= s_tvalid;
			if (s2_go) v2_q <= v1_q && (act_s1 == ACT_TEST);
			if (s3_go) v3_q <= v2_q;
			if (out_free) out_v_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_s1 <= s_tuser[0];
			row_s1 <= s_tuser[2:1];
			for (int k = 0; k < 4; k++) begin
				col_s1[k] <= s_tdata[k*DATA_W +: DATA_W];
			end
			for (int k = 0; k < 3; k++) begin
				ca_s1[k] <= s_tdata[(4+k)*DATA_W +: DATA_W];
				cb_s1[k] <= s_tdata[(7+k)*DATA_W +: DATA_W];
			end
		end
	end

	assign row_wr.wr_en = v1_q && (act_s1 == ACT_LOAD);
	assign row_wr.row   = row_s1;
	assign row_wr.c1    = col_s1[0];
	assign row_wr.c2    = col_s1[1];
	assign row_wr.c3    = col_s1[2];
	assign row_wr.c4    = col_s1[3];

	fbc_plane_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (row_wr),
		.coef   (coef)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lo[k] = (ca_s1[k] < cb_s1[k]) ? ca_s1[k] : cb_s1[k];
			hi[k] = (ca_s1[k] < cb_s1[k]) ? cb_s1[k] : ca_s1[k];
		end
	end

	genvar gp;
	generate
		for (gp = 0; gp < NUM_PLANES; gp++) begin : g_plane
			logic deg;
			assign deg = (coef[gp][CO_X] == '0) && (coef[gp][CO_Y] == '0)
				&& (coef[gp][CO_Z] == '0);

			// a plane with no normal is used as (0,1,0,0)
			always_comb begin
				ops[gp].cx = deg ? '0 : coef[gp][CO_X];
				ops[gp].cy = deg ? COEF_W'(1) : coef[gp][CO_Y];
				ops[gp].cz = deg ? '0 : coef[gp][CO_Z];
				ops[gp].cw = deg ? '0 : coef[gp][CO_W];
				ops[gp].vx = coef[gp][CO_X][COEF_W-1] ? lo[0] : hi[0];
				ops[gp].vy = coef[gp][CO_Y][COEF_W-1] ? lo[1] : hi[1];
				ops[gp].vz = coef[gp][CO_Z][COEF_W-1] ? lo[2] : hi[2];
			end

			always_ff @(posedge clk) begin
				if (s2_go) ops_s2[gp] <= ops[gp];
			end

			fbc_plane_eval u_eval (
				.clk     (clk),
				.s3_en   (s3_go),
				.ops     (ops_s2[gp]),
				.outside (outside[gp])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (out_free) visible_q <= ~|outside;
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {7'b0, visible_q};

	`FBC_ASSERT_NEXT(a_load_retires, clk, arst_n,
		in_acc && (s_tuser[0] == ACT_LOAD), v1_q && row_wr.wr_en)
	`FBC_ASSERT_NOW(a_full_blocks_input, clk, arst_n,
		v1_q && (act_s1 == ACT_TEST) && v2_q && v3_q && out_v_q && !m_tready,
		!s_tready)
	`FBC_ASSERT_NEXT(a_s3_holds_on_stall, clk, arst_n,
		v3_q && out_v_q && !m_tready, v3_q)
	`FBC_ASSERT_NEXT(a_result_follows_s3, clk, arst_n,
		v3_q && out_free, out_v_q)

endmodule

`default_nettype wire
